// ===== hdl/rgb_to_yuv420_block_tiler_macros.svh =====
// Assertion helpers shared by the tiler RTL.
`ifndef RGB_TO_YUV420_BLOCK_TILER_MACROS_SVH
`define RGB_TO_YUV420_BLOCK_TILER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RYT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ryt check failed");
// next-cycle implication
`define RYT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ryt check failed");
`else
`define RYT_ASSERT_NOW(label, clk, rst, ante, cons)
`define RYT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/ryt_pkg.sv =====
package ryt_pkg;

   localparam int VALUE_W  = 12;
   localparam int CSR_DATA_W = 9;

   // configuration register indexes
   localparam logic CFG_WIDTH_BLOCKS  = 1'b0;
   localparam logic CFG_HEIGHT_BLOCKS = 1'b1;

   localparam logic [CSR_DATA_W-1:0] WIDTH_BLOCKS_RESET  = 9'd80;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_BLOCKS_RESET = 9'd60;

   typedef enum logic [1:0] {
      PLANE_Y = 2'd0,
      PLANE_U = 2'd1,
      PLANE_V = 2'd2
   } plane_type;

   // per-pixel position info carried down the pipeline
   typedef struct packed {
      logic [7:0] block_row;
      logic [7:0] block_col;
      logic [5:0] y_index;
      logic [5:0] c_index;
      logic       row_odd;
      logic       col_odd;
      logic       frame_end;
   } pixel_tag_type;

   function automatic logic [VALUE_W-1:0] sat12(input logic [VALUE_W:0] v);
      sat12 = v[VALUE_W] ? {VALUE_W{1'b1}} : v[VALUE_W-1:0];
   endfunction

endpackage

// ===== hdl/ryt_pos.sv =====
module ryt_pos #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic [ryt_pkg::CSR_DATA_W-1:0]       width_blocks,
   input  logic [ryt_pkg::CSR_DATA_W-1:0]       height_blocks,
   output ryt_pkg::pixel_tag_type               tag,
   output logic [$clog2(MAX_WIDTH)-2:0]         slot
);
   import ryt_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH) + 1;
   localparam int RW   = $clog2(MAX_HEIGHT) + 1;
   localparam int SLW  = $clog2(MAX_WIDTH) - 1;
   localparam int CBW  = (CW - 3 > 10) ? CW - 3 : 10;
   localparam int RBW  = (RW - 3 > 10) ? RW - 3 : 10;
   localparam logic [9:0] MAX_WB = 10'(MAX_WIDTH / 8);
   localparam logic [9:0] MAX_HB = 10'(MAX_HEIGHT / 8);

   logic [CW-1:0] col_ff, col_in, col_a, col_n;
   logic [RW-1:0] row_ff, row_in, row_a, row_b, row_n;
   logic [CSR_DATA_W-1:0] eb_w, eb_h;
   logic wrap_c, wrap_r;

   // size in blocks: zero means one, clip at the store limits
   always_comb begin
      if (width_blocks == '0) begin
         eb_w = CSR_DATA_W'(1);
      end else if ({1'b0, width_blocks} > MAX_WB) begin
         eb_w = MAX_WB[CSR_DATA_W-1:0];
      end else begin
         eb_w = width_blocks;
      end
      if (height_blocks == '0) begin
         eb_h = CSR_DATA_W'(1);
      end else if ({1'b0, height_blocks} > MAX_HB) begin
         eb_h = MAX_HB[CSR_DATA_W-1:0];
      end else begin
         eb_h = height_blocks;
      end
   end

   always_comb begin
      // re-normalize a position left outside a resized image
      col_a = col_ff;
      row_b = row_ff;
      if (CBW'(col_ff[CW-1:3]) >= CBW'(eb_w)) begin
         col_a = '0;
         row_b = row_ff + 1'b1;
      end
      row_a = row_b;
      if (RBW'(row_b[RW-1:3]) >= RBW'(eb_h)) begin
         row_a = '0;
      end

      col_n  = col_a + 1'b1;
      row_n  = row_a + 1'b1;
      wrap_c = CBW'(col_n[CW-1:3]) >= CBW'(eb_w);
      wrap_r = RBW'(row_n[RW-1:3]) >= RBW'(eb_h);

      col_in = wrap_c ? '0 : col_n;
      row_in = wrap_c ? (wrap_r ? '0 : row_n) : row_a;

      tag.block_row = 8'(row_a >> 3);
      tag.block_col = 8'(col_a >> 3);
      tag.y_index   = {row_a[2:0], col_a[2:0]};
      tag.c_index   = {2'b00, row_a[2:1], col_a[2:1]};
      tag.row_odd   = row_a[0];
      tag.col_odd   = col_a[0];
      tag.frame_end = wrap_c && wrap_r;
      slot          = col_a[SLW:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (step) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== hdl/ryt_csc.sv =====
module ryt_csc #(
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [7:0]                  red,
   input  logic [7:0]                  green,
   input  logic [7:0]                  blue,
   output logic [COEF_FRAC_BITS+7:0]   y_acc,
   output logic [COEF_FRAC_BITS+7:0]   u_acc,
   output logic [COEF_FRAC_BITS+7:0]   v_acc
);
   import ryt_pkg::*;

   localparam int F  = COEF_FRAC_BITS;
   localparam int KW = F;
   localparam int PW = F + 8;
   localparam int AW = F + 8;
   localparam int SW = F + 10;

   // Q.F coefficients, rounded to nearest
   localparam logic [KW-1:0] K_YR = KW'((299 * (2 ** F) + 500) / 1000);
   localparam logic [KW-1:0] K_YG = KW'((587 * (2 ** F) + 500) / 1000);
   localparam logic [KW-1:0] K_YB = KW'((114 * (2 ** F) + 500) / 1000);
   localparam logic [KW-1:0] K_UR = KW'((169 * (2 ** F) + 500) / 1000);
   localparam logic [KW-1:0] K_UG = KW'((331 * (2 ** F) + 500) / 1000);
   localparam logic [KW-1:0] K_UB = KW'((499 * (2 ** F) + 500) / 1000);
   localparam logic [KW-1:0] K_VR = KW'((499 * (2 ** F) + 500) / 1000);
   localparam logic [KW-1:0] K_VG = KW'((418 * (2 ** F) + 500) / 1000);
   localparam logic [KW-1:0] K_VB = KW'((813 * (2 ** F) + 5000) / 10000);
   localparam logic [SW-1:0] OFFSET = SW'(128) << F;

   logic [PW-1:0] p_yr_ff, p_yg_ff, p_yb_ff;
   logic [PW-1:0] p_ur_ff, p_ug_ff, p_ub_ff;
   logic [PW-1:0] p_vr_ff, p_vg_ff, p_vb_ff;
   logic [SW-1:0] y_sum, u_sum, v_sum;
   logic [AW-1:0] y_ff, u_ff, v_ff;

   // stage 1: nine constant products
   always_ff @(posedge clock) begin
      if (advance) begin
         p_yr_ff <= PW'(red)   * PW'(K_YR);
         p_yg_ff <= PW'(green) * PW'(K_YG);
         p_yb_ff <= PW'(blue)  * PW'(K_YB);
         p_ur_ff <= PW'(red)   * PW'(K_UR);
         p_ug_ff <= PW'(green) * PW'(K_UG);
         p_ub_ff <= PW'(blue)  * PW'(K_UB);
         p_vr_ff <= PW'(red)   * PW'(K_VR);
         p_vg_ff <= PW'(green) * PW'(K_VG);
         p_vb_ff <= PW'(blue)  * PW'(K_VB);
      end
   end

   // stage 2: sums, negative results clamp to zero
   always_comb begin
      y_sum = SW'(p_yr_ff) + SW'(p_yg_ff) + SW'(p_yb_ff);
      u_sum = OFFSET + SW'(p_ub_ff) - SW'(p_ur_ff) - SW'(p_ug_ff);
      v_sum = OFFSET + SW'(p_vr_ff) - SW'(p_vg_ff) - SW'(p_vb_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         y_ff <= y_sum[SW-1] ? '0 : y_sum[AW-1:0];
         u_ff <= u_sum[SW-1] ? '0 : u_sum[AW-1:0];
         v_ff <= v_sum[SW-1] ? '0 : v_sum[AW-1:0];
      end
   end

   assign y_acc = y_ff;
   assign u_acc = u_ff;
   assign v_acc = v_ff;

endmodule

// ===== hdl/ryt_chroma.sv =====
module ryt_chroma #(
   parameter int MAX_WIDTH      = 2048,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 rd_valid,
   input  logic [$clog2(MAX_WIDTH)-2:0]         rd_slot,
   input  logic                                 valid,
   input  logic [$clog2(MAX_WIDTH)-2:0]         slot,
   input  logic                                 row_odd,
   input  logic                                 col_odd,
   input  logic [COEF_FRAC_BITS+7:0]            u_acc,
   input  logic [COEF_FRAC_BITS+7:0]            v_acc,
   output logic [ryt_pkg::VALUE_W-1:0]          u_val,
   output logic [ryt_pkg::VALUE_W-1:0]          v_val
);
   import ryt_pkg::*;

   localparam int F     = COEF_FRAC_BITS;
   localparam int AW    = F + 8;
   localparam int PSW   = F + 9;
   localparam int TW    = F + 10;
   localparam int SLW   = $clog2(MAX_WIDTH) - 1;
   localparam int DEPTH = 2 ** SLW;
   localparam logic [TW:0] HALF = (TW + 1)'(2 ** (F - 3));

   // pair sums of the even row, U in the upper half
   logic [2*PSW-1:0] mem [DEPTH];
   logic [2*PSW-1:0] rd_ff;

   logic [AW-1:0]  left_u_ff, left_u_in, left_v_ff, left_v_in;
   logic [PSW-1:0] pair_u, pair_v;
   logic [TW:0]    tot_u, tot_v;

   // read one stage ahead; the same slot is rewritten only a full row later
   always_ff @(posedge clock) begin
      if (advance && rd_valid) begin
         rd_ff <= mem[rd_slot];
      end
      if (advance && valid && col_odd && !row_odd) begin
         mem[slot] <= {pair_u, pair_v};
      end
   end

   always_comb begin
      left_u_in = left_u_ff;
      left_v_in = left_v_ff;
      if (advance && valid && !col_odd) begin
         left_u_in = u_acc;
         left_v_in = v_acc;
      end
      pair_u = PSW'(left_u_ff) + PSW'(u_acc);
      pair_v = PSW'(left_v_ff) + PSW'(v_acc);
      tot_u  = (TW + 1)'(pair_u) + (TW + 1)'(rd_ff[2*PSW-1:PSW]) + HALF;
      tot_v  = (TW + 1)'(pair_v) + (TW + 1)'(rd_ff[PSW-1:0]) + HALF;
      u_val  = sat12(tot_u[TW:F-2]);
      v_val  = sat12(tot_v[TW:F-2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_u_ff <= '0;
         left_v_ff <= '0;
      end else begin
         left_u_ff <= left_u_in;
         left_v_ff <= left_v_in;
      end
   end

endmodule

// ===== hdl/rgb_to_yuv420_block_tiler.sv =====
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_ready    req_red, req_green, req_blue
// rsp       out        rsp_valid / rsp_ready    plane, block pos, index, value, flags
// csr       in         csr_we (no wait)         csr_index, csr_wdata
//
// Rate: one item per cycle in while the output stage is free; a pixel gives one result or,
//    at odd row and odd column, three results, taken as rsp_ready allows.
// Path: an accepted item passes the product, accumulator and output registers before its first result.
// Reset: counters, left chroma and valid bits clear at once; the pair store needs
//    no clearing pass, every entry is written on an even row before an odd row reads it.
// Stalls: the whole pipeline holds while the output stage still has results.
`include "rgb_to_yuv420_block_tiler_macros.svh"

module rgb_to_yuv420_block_tiler #(
   parameter int MAX_WIDTH      = 2048,
   parameter int MAX_HEIGHT     = 2048,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // pixel input
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_red,
   input  logic [7:0]                       req_green,
   input  logic [7:0]                       req_blue,
   // sample output
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_plane,
   output logic [7:0]                       rsp_block_row,
   output logic [7:0]                       rsp_block_col,
   output logic [5:0]                       rsp_sample_index,
   output logic [ryt_pkg::VALUE_W-1:0]      rsp_sample_value,
   output logic                             rsp_last_of_run,
   output logic                             rsp_end_of_frame,
   // register writes
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [ryt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ryt_pkg::*;

   localparam int F   = COEF_FRAC_BITS;
   localparam int AW  = F + 8;
   localparam int SLW = $clog2(MAX_WIDTH) - 1;
   localparam logic [F+8:0] Y_HALF = (F + 9)'(2 ** (F - 5));

   logic [CSR_DATA_W-1:0] width_blocks_ff, height_blocks_ff;

   logic          advance, accept;
   pixel_tag_type tag0, tag1_ff, tag2_ff, tag_o_ff;
   logic [SLW-1:0] slot0, slot1_ff, slot2_ff;
   logic          v1_ff, v2_ff;

   logic [AW-1:0]      y_acc, u_acc, v_acc;
   logic [F+8:0]       y_round;
   logic [VALUE_W-1:0] y_val, u_val, v_val;
   logic [VALUE_W-1:0] y_o_ff, u_o_ff, v_o_ff;

   logic      out_valid_ff, out_valid_in, has_c_ff;
   plane_type phase_ff, phase_in;
   logic      last;

   // ---------------- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_blocks_ff  <= WIDTH_BLOCKS_RESET;
         height_blocks_ff <= HEIGHT_BLOCKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CFG_WIDTH_BLOCKS:  width_blocks_ff  <= csr_wdata;
            CFG_HEIGHT_BLOCKS: height_blocks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control
   // every stage moves together; the output stage frees on its last result
   assign last    = (phase_ff == PLANE_Y && !has_c_ff) || phase_ff == PLANE_V;
   assign advance = !out_valid_ff || (rsp_ready && last);
   assign accept  = req_valid && advance;
   assign req_ready = advance;

   ryt_pos #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_pos (
      .clock         (clock),
      .reset         (reset),
      .step          (accept),
      .width_blocks  (width_blocks_ff),
      .height_blocks (height_blocks_ff),
      .tag           (tag0),
      .slot          (slot0)
   );

   // stage 1 holds products, stage 2 holds accumulators
   ryt_csc #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_csc (
      .clock   (clock),
      .advance (advance),
      .red     (req_red),
      .green   (req_green),
      .blue    (req_blue),
      .y_acc   (y_acc),
      .u_acc   (u_acc),
      .v_acc   (v_acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag1_ff  <= tag0;
         slot1_ff <= slot0;
         tag2_ff  <= tag1_ff;
         slot2_ff <= slot1_ff;
      end
   end

   // pair store lookup issued from stage 1, used in stage 2
   ryt_chroma #(
      .MAX_WIDTH      (MAX_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_chroma (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .rd_valid (v1_ff),
      .rd_slot  (slot1_ff),
      .valid    (v2_ff),
      .slot     (slot2_ff),
      .row_odd  (tag2_ff.row_odd),
      .col_odd  (tag2_ff.col_odd),
      .u_acc    (u_acc),
      .v_acc    (v_acc),
      .u_val    (u_val),
      .v_val    (v_val)
   );

   // luma: round to 4 fraction bits
   assign y_round = (F + 9)'(y_acc) + Y_HALF;
   assign y_val   = sat12(y_round[F+8:F-4]);

   // ---------------- output stage: Y, then U and V when the 2x2 group closes
   always_comb begin
      out_valid_in = out_valid_ff;
      phase_in     = phase_ff;
      if (advance) begin
         out_valid_in = v2_ff;
         phase_in     = PLANE_Y;
      end else if (rsp_ready) begin
         case (phase_ff)
            PLANE_Y: phase_in = PLANE_U;
            PLANE_U: phase_in = PLANE_V;
            default: phase_in = phase_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= PLANE_Y;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         has_c_ff <= tag2_ff.row_odd && tag2_ff.col_odd;
         tag_o_ff <= tag2_ff;
         y_o_ff   <= y_val;
         u_o_ff   <= u_val;
         v_o_ff   <= v_val;
      end
   end

   always_comb begin
      rsp_valid        = out_valid_ff;
      rsp_plane        = phase_ff;
      rsp_block_row    = tag_o_ff.block_row;
      rsp_block_col    = tag_o_ff.block_col;
      rsp_last_of_run  = last;
      rsp_end_of_frame = last && tag_o_ff.frame_end;
      case (phase_ff)
         PLANE_Y: begin
            rsp_sample_index = tag_o_ff.y_index;
            rsp_sample_value = y_o_ff;
         end
         PLANE_U: begin
            rsp_sample_index = tag_o_ff.c_index;
            rsp_sample_value = u_o_ff;
         end
         default: begin
            rsp_sample_index = tag_o_ff.c_index;
            rsp_sample_value = v_o_ff;
         end
      endcase
   end

   // ---------------- checks
   `RYT_ASSERT_NOW(a_chroma_only_on_group, clock, reset, out_valid_ff && phase_ff != PLANE_Y, has_c_ff && tag_o_ff.row_odd && tag_o_ff.col_odd)
   `RYT_ASSERT_NEXT(a_run_continues, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_run, rsp_valid)
   `RYT_ASSERT_NEXT(a_u_then_v, clock, reset, rsp_valid && rsp_ready && phase_ff == PLANE_U, phase_ff == PLANE_V)
   `RYT_ASSERT_NEXT(a_accept_tracked, clock, reset, req_valid && req_ready, v1_ff)

endmodule
